>>> rtl/core/ascii_integer_parser_core_macros.svh
// assertion helpers for the ascii integer parser core
`ifndef ASCII_INTEGER_PARSER_CORE_MACROS_SVH
`define ASCII_INTEGER_PARSER_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define AIP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define AIP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/aip_pkg.sv
package aip_pkg;

    typedef struct packed {
        logic [7:0] ch;
        logic       has_char;
        logic       first;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic [63:0] value;
        logic        valid_res;
    } t_out_item;

    typedef struct packed {
        logic       radix_mode;
        logic [5:0] radix;
        logic       wide_result;
        logic       signed_result;
    } t_cfg;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] REG_RADIX_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RADIX         = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDE_RESULT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIGNED_RESULT = 2'd3;

    localparam logic [5:0] RADIX_RESET = 6'd10;

endpackage

>>> rtl/core/aip_in_reg.sv
module aip_in_reg
    import aip_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    input  logic     i_drain,
    output logic     o_valid,
    output t_in_item o_item
);

    logic     r_valid;
    logic     n_valid;
    t_in_item r_item;

    assign o_ready = !r_valid || i_drain;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_valid = r_valid;
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
        end else if (i_drain) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

>>> rtl/core/aip_engine.sv
module aip_engine
    import aip_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output logic      o_res_valid,
    output t_out_item o_res
);

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [5:0] BAD_DIGIT = 6'h3F;

    function automatic logic [5:0] digit_of(input logic [7:0] c);
        logic [7:0] t;
        t = 8'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            t = c - 8'h30;
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            t = c - 8'd87;
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            t = c - 8'd55;
        end else begin
            t = {2'b00, BAD_DIGIT};
        end
        return t[5:0];
    endfunction

    logic [63:0] r_acc;
    logic        r_neg;
    logic        r_hex;
    logic [1:0]  r_pos;
    logic        r_seen;
    logic        r_rej;

    logic [63:0] n_acc;
    logic        n_neg;
    logic        n_hex;
    logic [1:0]  n_pos;
    logic        n_seen;
    logic        n_rej;

    // state seen by this byte, after an optional clear on first
    logic [63:0] b_acc;
    logic        b_neg;
    logic        b_hex;
    logic [1:0]  b_pos;
    logic        b_seen;
    logic        b_rej;

    logic [63:0] u_acc;
    logic        u_neg;
    logic        u_hex;
    logic [1:0]  u_pos;
    logic        u_seen;
    logic        u_rej;

    logic [5:0]  dig;
    logic [63:0] limit;
    logic [67:0] sum16;
    logic [67:0] sum10;
    logic        ovf16;
    logic        ovf10;
    logic [5:0]  base;
    logic [37:0] rmul;
    logic [31:0] rsum;
    logic        ok;
    logic [63:0] neg_acc;

    always_comb begin
        b_acc  = i_item.first ? 64'd0 : r_acc;
        b_neg  = i_item.first ? 1'b0  : r_neg;
        b_hex  = i_item.first ? 1'b0  : r_hex;
        b_pos  = i_item.first ? 2'd0  : r_pos;
        b_seen = i_item.first ? 1'b0  : r_seen;
        b_rej  = i_item.first ? 1'b0  : r_rej;
    end

    assign dig = digit_of(i_item.ch);

    always_comb begin
        unique case ({i_cfg.wide_result, i_cfg.signed_result})
            2'b00:   limit = 64'h0000_0000_FFFF_FFFF;
            2'b01:   limit = 64'h0000_0000_7FFF_FFFF;
            2'b10:   limit = 64'hFFFF_FFFF_FFFF_FFFF;
            default: limit = 64'h7FFF_FFFF_FFFF_FFFF;
        endcase
    end

    // exact acc * base + d against the limit, four guard bits on top
    assign sum16 = {b_acc, 4'b0000} + {62'd0, dig};
    assign sum10 = {1'b0, b_acc, 3'b000} + {3'b000, b_acc, 1'b0} + {62'd0, dig};
    assign ovf16 = sum16 > {4'b0000, limit};
    assign ovf10 = sum10 > {4'b0000, limit};

    always_comb begin
        if (i_cfg.radix < 6'd2) begin
            base = 6'd2;
        end else if (i_cfg.radix > 6'd36) begin
            base = 6'd36;
        end else begin
            base = i_cfg.radix;
        end
    end

    assign rmul = {6'd0, b_acc[31:0]} * {32'd0, base};
    assign rsum = rmul[31:0] + {26'd0, dig};

    always_comb begin
        u_acc  = b_acc;
        u_neg  = b_neg;
        u_hex  = b_hex;
        u_seen = b_seen;
        u_rej  = b_rej;
        u_pos  = b_pos;
        if (i_item.has_char) begin
            if (b_pos != 2'd2) begin
                u_pos = b_pos + 2'd1;
            end
            if (!b_rej) begin
                if (i_cfg.radix_mode) begin
                    if (dig >= base) begin
                        u_rej = 1'b1;
                    end else begin
                        u_acc  = {32'd0, rsum};
                        u_seen = 1'b1;
                    end
                end else begin
                    priority if (b_hex) begin
                        if (dig > 6'd15 || ovf16) begin
                            u_rej = 1'b1;
                        end else begin
                            u_acc = sum16[63:0];
                        end
                    end else if (b_pos == 2'd1 && b_seen && !b_neg && b_acc == 64'd0
                                 && (i_item.ch == CH_LO_X || i_item.ch == CH_UP_X)) begin
                        u_hex = 1'b1;
                    end else if (b_pos == 2'd0 && i_item.ch == CH_MINUS) begin
                        u_neg = 1'b1;
                    end else if (dig <= 6'd9) begin
                        // an overflowing digit still counts as seen
                        u_seen = 1'b1;
                        if (ovf10) begin
                            u_rej = 1'b1;
                        end else begin
                            u_acc = sum10[63:0];
                        end
                    end else begin
                        u_rej = 1'b1;
                    end
                end
            end
        end
    end

    assign neg_acc = 64'd0 - u_acc;

    always_comb begin
        if (i_cfg.radix_mode) begin
            ok = !u_rej;
        end else begin
            ok = !u_rej && u_pos != 2'd0 && (u_hex || u_seen);
        end
        o_res.valid_res = ok;
        o_res.value     = 64'd0;
        if (ok) begin
            if (i_cfg.radix_mode) begin
                o_res.value = {32'd0, u_acc[31:0]};
            end else if (i_cfg.wide_result) begin
                o_res.value = u_neg ? neg_acc : u_acc;
            end else begin
                o_res.value = {32'd0, u_neg ? neg_acc[31:0] : u_acc[31:0]};
            end
        end
    end

    assign o_res_valid = i_en && i_item.last;

    always_comb begin
        n_acc  = r_acc;
        n_neg  = r_neg;
        n_hex  = r_hex;
        n_pos  = r_pos;
        n_seen = r_seen;
        n_rej  = r_rej;
        if (i_en) begin
            if (i_item.last) begin
                n_acc  = 64'd0;
                n_neg  = 1'b0;
                n_hex  = 1'b0;
                n_pos  = 2'd0;
                n_seen = 1'b0;
                n_rej  = 1'b0;
            end else begin
                n_acc  = u_acc;
                n_neg  = u_neg;
                n_hex  = u_hex;
                n_pos  = u_pos;
                n_seen = u_seen;
                n_rej  = u_rej;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= 64'd0;
            r_neg  <= 1'b0;
            r_hex  <= 1'b0;
            r_pos  <= 2'd0;
            r_seen <= 1'b0;
            r_rej  <= 1'b0;
        end else begin
            r_acc  <= n_acc;
            r_neg  <= n_neg;
            r_hex  <= n_hex;
            r_pos  <= n_pos;
            r_seen <= n_seen;
            r_rej  <= n_rej;
        end
    end

endmodule

>>> rtl/core/aip_out_reg.sv
module aip_out_reg
    import aip_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_out_item i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    logic      r_valid;
    logic      n_valid;
    t_out_item r_item;

    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

endmodule

>>> rtl/core/ascii_integer_parser_core.sv
// ascii integer parser: one text byte per transfer on the input channel,
// one result per text on the output channel (valid/ready on both).
// a transfer with last set closes the text and yields value and valid_res;
// has_char low with first and last set is an empty text.
// configuration is a plain write port (enable, index, data), to be written
// only while the block is idle, which the block itself does not enforce:
// 0 radix_mode, 1 radix, 2 wide_result, 3 signed_result.
// a byte is captured in the input register at its transfer and parsed from
// there into the state registers; a closing byte's result is registered in
// the output register and offered from there. throughput is one byte per
// cycle while no closing byte waits for room, bounded by the single accumulator
// update (shift-add by 10 or 16, or a 32x6 multiply in radix mode).
// reset clears the parse state and both registers and loads the register
// defaults (prefix mode, radix 10, 32-bit, signed).
// when the receiver stalls, the result waits in the output register; bytes
// that produce no result keep flowing, and a closing byte waits in the
// input register, which then holds off further transfers.
module ascii_integer_parser_core
    import aip_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    `include "ascii_integer_parser_core_macros.svh"

    t_cfg      r_cfg;
    t_cfg      n_cfg;
    logic      stg_valid;
    t_in_item  stg_item;
    logic      fire;
    logic      res_load;
    t_out_item res_item;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_RADIX_MODE:    n_cfg.radix_mode    = i_cfg_wdata[0];
                REG_RADIX:         n_cfg.radix         = i_cfg_wdata;
                REG_WIDE_RESULT:   n_cfg.wide_result   = i_cfg_wdata[0];
                REG_SIGNED_RESULT: n_cfg.signed_result = i_cfg_wdata[0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.radix_mode    <= 1'b0;
            r_cfg.radix         <= RADIX_RESET;
            r_cfg.wide_result   <= 1'b0;
            r_cfg.signed_result <= 1'b1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // a closing byte needs room in the output register
    assign fire = stg_valid && (!stg_item.last || !o_out_valid || i_out_ready);

    aip_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in_item),
        .i_drain (fire),
        .o_valid (stg_valid),
        .o_item  (stg_item)
    );

    aip_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (fire),
        .i_item      (stg_item),
        .i_cfg       (r_cfg),
        .o_res_valid (res_load),
        .o_res       (res_item)
    );

    aip_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_load),
        .i_item  (res_item),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

    `AIP_ASSERT_IMP(a_no_overwrite, res_load && o_out_valid, i_out_ready, "result overwritten while stalled")
    `AIP_ASSERT_NXT(a_load_shows, res_load, o_out_valid, "loaded result not offered")
    `AIP_ASSERT_IMP(a_reject_zero, o_out_valid && !o_out_item.valid_res, o_out_item.value == 64'd0, "rejected text with nonzero value")

endmodule
